[rtl/nfha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types and codes for the next-fit heap allocator
// no dependencies

package nfha_pkg;

	// width of the byte offsets and request sizes on the ports
	localparam int OFF_W = 12;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ARD,
		ST_ACHK,
		ST_RRD,
		ST_RCHK,
		ST_MRD,
		ST_MCHK,
		ST_FIT,
		ST_SPLIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/nfha_hdr_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// block header store: one write port, one registered read port
// no dependencies

module nfha_hdr_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/next_fit_heap_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// next-fit heap allocator: block headers (free mark, payload size) live in one synchronous
// memory indexed by byte offset; a sequencer walks them one block at a time (read, then
// check). allocate starts at the roving pointer, merges free neighbors forward (never past the
// heap end), takes the first fitting block and splits it when the rest is big enough. release
// first walks the chain from offset 0 to prove the offset is a block start, then frees and
// merges. one word is worked on at a time; a word takes a read and a check state per block
// visited and per merge probe (each absorbed block plus the one that stops the merge, none at
// the heap end), a fit state per free block tried, a split state, a done state to hand over
// the result and an idle state to take the next word, so the time per word is set by heap
// fragmentation. a release with an offset outside the heap goes from idle straight to done.
// after reset an init state writes the initial free block before the first word is taken.
// depends on nfha_pkg and nfha_hdr_mem

module next_fit_heap_allocator #(
	parameter int HEAP_BYTES      = 4096,
	parameter int HEADER_BYTES    = 16,
	parameter int MIN_SPLIT_BYTES = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       cmd,
	input  wire logic [nfha_pkg::OFF_W-1:0] request_bytes,
	input  wire logic [nfha_pkg::OFF_W-1:0] release_offset,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            ok,
	output logic      [nfha_pkg::OFF_W-1:0] payload_offset
);

	localparam int OW = nfha_pkg::OFF_W;
	// address bits of a header slot
	localparam int AW = $clog2(HEAP_BYTES);
	// positions up to and past the heap end
	localparam int EW = AW + 2;
	// size comparisons against request plus header plus split minimum
	localparam int CW = ((AW > OW) ? AW : OW) + 10;

	nfha_pkg::state_t state_q, state_d;

	logic              cmd_q;
	logic [OW-1:0]     want_q;
	logic [EW-1:0]     h_q;      // header offset being released
	logic [AW-1:0]     cur_q;    // block under inspection
	logic [AW-1:0]     base_q;   // free block that absorbs its neighbors
	logic [AW-1:0]     bsize_q;  // running payload size of base
	logic [EW-1:0]     scan_q;   // next block to try merging
	logic [AW-1:0]     rp_q;     // roving pointer
	logic              res_ok_q;
	logic [OW-1:0]     res_off_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [OW-1:0]     payload_offset_q;

	// header memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [AW:0]   mem_rdata;
	logic          rd_free;
	logic [AW-1:0] rd_size;

	nfha_hdr_mem #(
		.DEPTH(HEAP_BYTES),
		.AW   (AW),
		.DW   (AW + 1)
	) u_hdr_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_free = mem_rdata[AW];
	assign rd_size = mem_rdata[AW-1:0];

	// block arithmetic
	logic          in_acc;
	logic          done_go;
	logic [EW-1:0] cur_end;
	logic [EW-1:0] scan_end;
	logic [EW-1:0] base_end;
	logic [AW-1:0] cur_next;
	logic [AW-1:0] base_next;
	logic [AW-1:0] merged;
	logic          fits;
	logic          no_split;
	logic [EW-1:0] rest;
	logic [AW-1:0] rest_size;
	logic          rel_in_range;
	logic [EW-1:0] rel_h;

	assign in_acc  = in_valid && !in_stall;
	assign done_go = !out_valid_q || !out_stall;

	assign cur_end  = EW'(cur_q) + EW'(HEADER_BYTES) + EW'(rd_size);
	assign scan_end = scan_q + EW'(HEADER_BYTES) + EW'(rd_size);
	assign base_end = EW'(base_q) + EW'(HEADER_BYTES) + EW'(bsize_q);
	// wrap at heap end for the walk
	assign cur_next  = (cur_end >= EW'(HEAP_BYTES)) ? '0 : cur_end[AW-1:0];
	assign base_next = (base_end >= EW'(HEAP_BYTES)) ? '0 : base_end[AW-1:0];
	assign merged    = AW'(EW'(bsize_q) + EW'(HEADER_BYTES) + EW'(rd_size));

	assign fits     = CW'(bsize_q) >= CW'(want_q);
	assign no_split = CW'(bsize_q) <
		(CW'(want_q) + CW'(HEADER_BYTES) + CW'(MIN_SPLIT_BYTES));
	assign rest      = EW'(base_q) + EW'(HEADER_BYTES) + EW'(want_q);
	assign rest_size = AW'(CW'(bsize_q) - CW'(want_q) - CW'(HEADER_BYTES));

	assign rel_h        = EW'(release_offset) - EW'(HEADER_BYTES);
	assign rel_in_range = (EW'(release_offset) >= EW'(HEADER_BYTES)) &&
		(rel_h < EW'(HEAP_BYTES));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfha_pkg::ST_INIT: begin
				state_d = nfha_pkg::ST_IDLE;
			end
			nfha_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (nfha_pkg::cmd_t'(cmd) == nfha_pkg::CMD_ALLOC) begin
						state_d = nfha_pkg::ST_ARD;
					end else if (rel_in_range) begin
						state_d = nfha_pkg::ST_RRD;
					end else begin
						state_d = nfha_pkg::ST_DONE;
					end
				end
			end
			nfha_pkg::ST_ARD: state_d = nfha_pkg::ST_ACHK;
			nfha_pkg::ST_RRD: state_d = nfha_pkg::ST_RCHK;
			nfha_pkg::ST_MRD: state_d = nfha_pkg::ST_MCHK;
			nfha_pkg::ST_ACHK: begin
				if (rd_free) begin
					state_d = (cur_end < EW'(HEAP_BYTES)) ? nfha_pkg::ST_MRD : nfha_pkg::ST_FIT;
				end else if (cur_next == rp_q) begin
					state_d = nfha_pkg::ST_DONE;
				end else begin
					state_d = nfha_pkg::ST_ARD;
				end
			end
			nfha_pkg::ST_RCHK: begin
				if (EW'(cur_q) == h_q) begin
					state_d = (cur_end < EW'(HEAP_BYTES)) ? nfha_pkg::ST_MRD : nfha_pkg::ST_FIT;
				end else if (cur_end > h_q || cur_end >= EW'(HEAP_BYTES)) begin
					state_d = nfha_pkg::ST_DONE;
				end else begin
					state_d = nfha_pkg::ST_RRD;
				end
			end
			nfha_pkg::ST_MCHK: begin
				if (rd_free && scan_end < EW'(HEAP_BYTES)) begin
					state_d = nfha_pkg::ST_MRD;
				end else begin
					state_d = nfha_pkg::ST_FIT;
				end
			end
			nfha_pkg::ST_FIT: begin
				if (nfha_pkg::cmd_t'(cmd_q) == nfha_pkg::CMD_RELEASE) begin
					state_d = nfha_pkg::ST_DONE;
				end else if (fits) begin
					state_d = no_split ? nfha_pkg::ST_DONE : nfha_pkg::ST_SPLIT;
				end else if (base_next == rp_q) begin
					state_d = nfha_pkg::ST_DONE;
				end else begin
					state_d = nfha_pkg::ST_ARD;
				end
			end
			nfha_pkg::ST_SPLIT: state_d = nfha_pkg::ST_DONE;
			nfha_pkg::ST_DONE: begin
				if (done_go) begin
					state_d = nfha_pkg::ST_IDLE;
				end
			end
			default: state_d = nfha_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base_q;
		mem_wdata = {1'b1, bsize_q};
		mem_raddr = cur_q;
		in_stall  = (state_q != nfha_pkg::ST_IDLE);
		unique case (state_q)
			nfha_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b1, AW'(HEAP_BYTES - HEADER_BYTES)};
			end
			nfha_pkg::ST_MRD: begin
				mem_raddr = scan_q[AW-1:0];
			end
			nfha_pkg::ST_FIT: begin
				mem_we = 1'b1;
				if (nfha_pkg::cmd_t'(cmd_q) == nfha_pkg::CMD_ALLOC && fits) begin
					mem_wdata = {1'b0, no_split ? bsize_q : AW'(want_q)};
				end
			end
			nfha_pkg::ST_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = rp_q;
				mem_wdata = {1'b1, rest_size};
			end
			default: begin
			end
		endcase
	end

	// walk datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nfha_pkg::ST_INIT;
			rp_q     <= '0;
			res_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				nfha_pkg::ST_IDLE: begin
					if (in_acc) begin
						cmd_q     <= cmd;
						want_q    <= request_bytes;
						h_q       <= rel_h;
						res_ok_q  <= 1'b0;
						res_off_q <= '0;
						cur_q     <= (nfha_pkg::cmd_t'(cmd) == nfha_pkg::CMD_ALLOC) ? rp_q : '0;
					end
				end
				nfha_pkg::ST_ACHK: begin
					base_q  <= cur_q;
					bsize_q <= rd_size;
					scan_q  <= cur_end;
					cur_q   <= cur_next;
				end
				nfha_pkg::ST_RCHK: begin
					base_q  <= cur_q;
					bsize_q <= rd_size;
					scan_q  <= cur_end;
					cur_q   <= cur_end[AW-1:0];
				end
				nfha_pkg::ST_MCHK: begin
					if (rd_free) begin
						bsize_q <= merged;
						scan_q  <= scan_end;
						// absorbed roving pointer moves to the merged block
						if (EW'(rp_q) == scan_q) begin
							rp_q <= base_q;
						end
					end
				end
				nfha_pkg::ST_FIT: begin
					if (nfha_pkg::cmd_t'(cmd_q) == nfha_pkg::CMD_RELEASE) begin
						res_ok_q <= 1'b1;
					end else if (fits) begin
						res_ok_q  <= 1'b1;
						res_off_q <= OW'(EW'(base_q) + EW'(HEADER_BYTES));
						rp_q      <= no_split ? base_next : rest[AW-1:0];
					end else begin
						cur_q <= base_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == nfha_pkg::ST_DONE && done_go) begin
				out_valid_q      <= 1'b1;
				ok_q             <= res_ok_q;
				payload_offset_q <= res_off_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign payload_offset = payload_offset_q;

	// a result only appears after the sequencer finishes a word
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == nfha_pkg::ST_DONE))
		else $error("result without finished word");

	// roving pointer stays inside the heap
	a_rp_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(rp_q) < EW'(HEAP_BYTES))
		else $error("roving pointer past heap end");

	// merged block never runs past the heap end
	a_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nfha_pkg::ST_FIT |-> base_end <= EW'(HEAP_BYTES))
		else $error("merged block past heap end");

	// header store is untouched while waiting for a word or handing over a result
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfha_pkg::ST_IDLE || state_q == nfha_pkg::ST_DONE) |-> !mem_we)
		else $error("header write while idle");

	// a split remainder starts right after the taken block
	a_split_place: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nfha_pkg::ST_SPLIT |->
		EW'(rp_q) == EW'(base_q) + EW'(HEADER_BYTES) + EW'(want_q))
		else $error("split remainder misplaced");

endmodule

`default_nettype wire
